// ===== rtl/led_strip_pulse_encoder_top_assert.svh =====
// ----------------------------------------------------------------------------
// LED strip pulse encoder assertion macros
// Shared concurrent assertion forms, clocked on i_clk and off during reset.
// ----------------------------------------------------------------------------
`ifndef LED_STRIP_PULSE_ENCODER_TOP_ASSERT_SVH
`define LED_STRIP_PULSE_ENCODER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSPE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LSPE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lspe_pkg.sv =====
// ----------------------------------------------------------------------------
// LED strip pulse encoder package
// Command codes, register indexes, reset values and control structs.
// ----------------------------------------------------------------------------
`default_nettype none

package lspe_pkg;

    localparam int LED_COUNT_DEF = 64;

    localparam int CMD_W   = 3;
    localparam int LED_NUM_W = 8;
    localparam int CHAN_W  = 8;
    localparam int COLOR_W = 3 * CHAN_W;
    localparam int CODE_W  = 16;
    localparam int RW_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int SLOTS_PER_LED = 24;
    localparam int BIT_SEL_W = 5;

    localparam logic [CMD_W-1:0] CMD_SET_ALL   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET_INDEX = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SET_RANGE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ALL_OFF   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_NEXT_CODE = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_RESET_WORDS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_ONE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_ZERO   = 2'd2;

    localparam logic [RW_W-1:0]   RESET_WORDS_RST = 8'd50;
    localparam logic [CODE_W-1:0] CODE_ONE_RST    = 16'd60;
    localparam logic [CODE_W-1:0] CODE_ZERO_RST   = 16'd30;

    localparam logic [BIT_SEL_W-1:0] TOP_BIT = 5'd23;

    typedef struct packed {
        logic load;       // capture the accepted item
        logic pos_clear;  // restart the frame
        logic pos_step;   // advance the frame position, decode the slot
        logic mul;        // capture the slot divide product
        logic addr_rd;    // read the addressed colour
        logic sweep_wr;   // write one store entry and advance the sweep index
        logic wr_zero;    // sweep writes zero regardless of the command
        logic out_load;   // capture the result into the output register
    } t_ctl;

    typedef struct packed {
        logic sweep_last; // sweep index is on the last LED
    } t_stat;

endpackage

`default_nettype wire

// ===== rtl/lspe_ctrl.sv =====
// ----------------------------------------------------------------------------
// LED strip pulse encoder controller
// Sequences store sweeps, slot decoding and the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

`include "led_strip_pulse_encoder_top_assert.svh"

module lspe_ctrl
    import lspe_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic [CMD_W-1:0] i_command,
    input  wire logic             i_out_ready,
    input  wire t_stat            i_stat,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    output t_ctl                  o_ctl
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SWEEP,
        S_POS,
        S_MUL,
        S_ADDR,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   accept;
    logic   is_edit;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign is_edit     = (i_command == CMD_SET_ALL) || (i_command == CMD_SET_INDEX) ||
                         (i_command == CMD_SET_RANGE) || (i_command == CMD_ALL_OFF);

    always_comb begin
        o_ctl           = '0;
        o_ctl.load      = accept;
        o_ctl.pos_clear = accept && is_edit;
        o_ctl.pos_step  = (r_state == S_POS);
        o_ctl.mul       = (r_state == S_MUL);
        o_ctl.addr_rd   = (r_state == S_ADDR);
        o_ctl.sweep_wr  = (r_state == S_SWEEP) || (r_state == S_CLEAR);
        o_ctl.wr_zero   = (r_state == S_CLEAR);
        o_ctl.out_load  = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    if (is_edit) n_state = S_SWEEP;
                    else if (i_command == CMD_NEXT_CODE) n_state = S_POS;
                    else n_state = S_DONE;
                end
            end
            S_SWEEP: begin
                if (i_stat.sweep_last) n_state = S_DONE;
            end
            S_POS:  n_state = S_MUL;
            S_MUL:  n_state = S_ADDR;
            S_ADDR: n_state = S_DONE;
            S_DONE: begin
                if (o_ctl.out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // A pending result is never overwritten before it has been transferred.
    `LSPE_ASSERT_NOW(a_out_no_overwrite, o_ctl.out_load, !r_out_valid || i_out_ready, "result overwritten before transfer")
    // A sweep ends exactly when the last entry is written.
    `LSPE_ASSERT_NEXT(a_sweep_end, (r_state == S_SWEEP) && i_stat.sweep_last, r_state == S_DONE, "sweep did not end on the last LED")
    // A next_code transfer always goes through slot decoding.
    `LSPE_ASSERT_NEXT(a_next_decode, accept && (i_command == CMD_NEXT_CODE), r_state == S_POS, "next_code skipped slot decoding")
    // The store clearing pass after reset never overlaps an input transfer.
    `LSPE_ASSERT_NOW(a_clear_blocks, o_ctl.wr_zero, !o_in_ready && !o_ctl.load, "input taken during clearing pass")

endmodule

`default_nettype wire

// ===== rtl/lspe_datapath.sv =====
// ----------------------------------------------------------------------------
// LED strip pulse encoder datapath
// Colour store, frame position, slot decode and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lspe_datapath
    import lspe_pkg::*;
#(
    parameter int LED_COUNT = LED_COUNT_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_ctl                  i_ctl,
    output t_stat                      o_stat,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [CMD_W-1:0]      i_command,
    input  wire logic [LED_NUM_W-1:0]  i_first_led,
    input  wire logic [LED_NUM_W-1:0]  i_last_led,
    input  wire logic [CHAN_W-1:0]     i_red,
    input  wire logic [CHAN_W-1:0]     i_green,
    input  wire logic [CHAN_W-1:0]     i_blue,
    output logic                       o_status,
    output logic [CODE_W-1:0]          o_pulse_code,
    output logic                       o_frame_end
);

    localparam int LED_W   = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int CMP_W   = (LED_W + 1 > LED_NUM_W) ? LED_W + 1 : LED_NUM_W;
    localparam int DATA_SLOTS = SLOTS_PER_LED * LED_COUNT;
    localparam int POS_MAX = (2 ** RW_W) - 1 + DATA_SLOTS;
    localparam int POS_W   = $clog2(POS_MAX + 1);
    localparam int SLOT_W  = $clog2(DATA_SLOTS);
    localparam int X_W     = SLOT_W - 3;
    localparam int K       = X_W + 2;
    localparam int RECIP   = ((2 ** K) + 2) / 3;
    localparam int PROD_W  = X_W + K;

    // Configuration registers.
    logic [RW_W-1:0]   r_reset_words;
    logic [CODE_W-1:0] r_code_one;
    logic [CODE_W-1:0] r_code_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reset_words <= RESET_WORDS_RST;
            r_code_one    <= CODE_ONE_RST;
            r_code_zero   <= CODE_ZERO_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_RESET_WORDS: r_reset_words <= i_cfg_data[RW_W-1:0];
                CFG_CODE_ONE:    r_code_one    <= i_cfg_data;
                CFG_CODE_ZERO:   r_code_zero   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Captured item.
    logic [CMD_W-1:0]   r_cmd;
    logic [CMP_W-1:0]   r_first;
    logic [CMP_W-1:0]   r_last;
    logic [COLOR_W-1:0] r_color;
    logic               r_first_ok;
    logic               r_last_ok;
    logic               first_ok;
    logic               last_ok;

    assign first_ok = (i_first_led != '0) &&
                      (CMP_W'(i_first_led) <= CMP_W'(LED_COUNT));
    assign last_ok  = (i_last_led != '0) &&
                      (CMP_W'(i_last_led) <= CMP_W'(LED_COUNT));

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd      <= i_command;
            r_first    <= CMP_W'(i_first_led);
            r_last     <= CMP_W'(i_last_led);
            r_color    <= {i_green, i_red, i_blue};
            r_first_ok <= first_ok;
            r_last_ok  <= last_ok;
        end
    end

    // Store sweep: one entry per cycle over the whole strip.
    logic [LED_W-1:0]   r_idx;
    logic [CMP_W-1:0]   led_num;
    logic               hit;
    logic [COLOR_W-1:0] wr_data;

    assign led_num = CMP_W'(r_idx) + CMP_W'(1);
    assign o_stat.sweep_last = (r_idx == LED_W'(LED_COUNT - 1));

    always_comb begin
        hit = 1'b0;
        if (r_cmd == CMD_SET_ALL) begin
            hit = 1'b1;
        end else if (r_cmd == CMD_SET_INDEX) begin
            hit = r_first_ok && (led_num == r_first);
        end else if (r_cmd == CMD_SET_RANGE) begin
            hit = r_first_ok && r_last_ok && (led_num >= r_first) && (led_num <= r_last);
        end
        wr_data = (hit && !i_ctl.wr_zero) ? r_color : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_ctl.sweep_wr) begin
            r_idx <= o_stat.sweep_last ? '0 : r_idx + LED_W'(1);
        end
    end

    logic [COLOR_W-1:0] r_mem [LED_COUNT];
    logic [COLOR_W-1:0] r_rd_data;
    logic [LED_W-1:0]   rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_ctl.sweep_wr) begin
            r_mem[r_idx] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.addr_rd) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Frame position and slot decode.
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  total;
    logic [POS_W-1:0]  pos_eff;
    logic [POS_W-1:0]  pos_inc;
    logic [POS_W-1:0]  slot_full;
    logic              at_end;
    logic              r_pre;
    logic              r_end;
    logic [X_W-1:0]    r_x;
    logic [2:0]        r_lo;

    assign total     = POS_W'(r_reset_words) + POS_W'(DATA_SLOTS);
    assign pos_eff   = (r_pos >= total) ? '0 : r_pos;
    assign pos_inc   = pos_eff + POS_W'(1);
    assign at_end    = (pos_inc == total);
    assign slot_full = pos_eff - POS_W'(r_reset_words);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_ctl.pos_clear) begin
            r_pos <= '0;
        end else if (i_ctl.pos_step) begin
            r_pos <= at_end ? '0 : pos_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.pos_step) begin
            r_pre <= (pos_eff < POS_W'(r_reset_words));
            r_end <= at_end;
            r_x   <= slot_full[SLOT_W-1:3];
            r_lo  <= slot_full[2:0];
        end
    end

    // Slot / 24 = (slot / 8) / 3, the divide by three by reciprocal multiply.
    logic [PROD_W-1:0]    r_prod;
    logic [X_W-1:0]       quot;
    logic [X_W-1:0]       rem_full;
    logic [BIT_SEL_W-1:0] r_bit_sel;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_prod <= PROD_W'(r_x) * PROD_W'(RECIP);
        end
    end

    assign quot     = r_prod[PROD_W-1:K];
    assign rem_full = r_x - (quot << 1) - quot;
    assign rd_addr  = quot[LED_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.addr_rd) begin
            r_bit_sel <= TOP_BIT - {rem_full[1:0], r_lo};
        end
    end

    // Result register.
    logic              is_next;
    logic              bad;
    logic [CODE_W-1:0] code;

    assign is_next = (r_cmd == CMD_NEXT_CODE);
    assign bad     = ((r_cmd == CMD_SET_INDEX) && !r_first_ok) ||
                     ((r_cmd == CMD_SET_RANGE) && !(r_first_ok && r_last_ok));
    assign code    = (!is_next || r_pre) ? '0 :
                     (r_rd_data[r_bit_sel] ? r_code_one : r_code_zero);

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            o_status     <= bad;
            o_pulse_code <= code;
            o_frame_end  <= is_next && r_end;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/led_strip_pulse_encoder_top.sv =====
// ----------------------------------------------------------------------------
// LED strip pulse encoder top level
// Holds a colour per LED and emits one frame of pulse-width codes slot by slot.
// ----------------------------------------------------------------------------
// An edit command sweeps the whole store, one store entry a cycle, before its result.
// A next_code goes through frame position, divide multiply, store read and output.
// Commands 5 to 7 go straight to the output. One item is in work at a time.
// Reset clears the frame position and loads register defaults, then a clearing
// pass writes zero to every store entry before the first item is taken.
`default_nettype none

module led_strip_pulse_encoder_top
    import lspe_pkg::*;
#(
    parameter int LED_COUNT = LED_COUNT_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [CMD_W-1:0]      i_command,
    input  wire logic [LED_NUM_W-1:0]  i_first_led,
    input  wire logic [LED_NUM_W-1:0]  i_last_led,
    input  wire logic [CHAN_W-1:0]     i_red,
    input  wire logic [CHAN_W-1:0]     i_green,
    input  wire logic [CHAN_W-1:0]     i_blue,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_status,
    output logic [CODE_W-1:0]          o_pulse_code,
    output logic                       o_frame_end
);

    t_ctl  ctl;
    t_stat stat;

    lspe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_command   (i_command),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_ctl       (ctl)
    );

    lspe_datapath #(
        .LED_COUNT (LED_COUNT)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .o_stat       (stat),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_command    (i_command),
        .i_first_led  (i_first_led),
        .i_last_led   (i_last_led),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .o_status     (o_status),
        .o_pulse_code (o_pulse_code),
        .o_frame_end  (o_frame_end)
    );

endmodule

`default_nettype wire

// ===== verif/tb_led_strip_pulse_encoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip pulse encoder testbench
// Drives store edits and code-slot requests through the valid/ready input,
// predicts every result from its own copy of the colour store and frame
// position, and compares each output transfer field by field. Covers
// out-of-range LED numbers, empty ranges, full frames with wrap and a frame
// shrunk by lowering reset_words.
// ----------------------------------------------------------------------------

module tb_led_strip_pulse_encoder_top;
    import lspe_pkg::*;

    localparam int NUM_LEDS         = LED_COUNT_DEF;
    localparam int FRAME_DATA_SLOTS = SLOTS_PER_LED * NUM_LEDS;
    localparam int STALL_LIMIT      = 5000;
    localparam int DRAIN_CYCLES     = NUM_LEDS + 8;
    localparam int RANDOM_ITEMS     = 700;
    localparam int MAX_REPORTS      = 10;

    localparam logic [CMD_W-1:0]     CMD_SPARE_FIRST = 3'd5;
    localparam logic [CMD_W-1:0]     CMD_SPARE_LAST  = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE       = 2'd3;

    typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PATTERN} t_ready_mode;

    typedef struct packed {
        logic              status;
        logic [CODE_W-1:0] pulse_code;
        logic              frame_end;
    } t_slot_result;

    // Colour store and frame position mirror, plus the results still owed.
    class pulse_frame_board;
        logic [COLOR_W-1:0] colors [NUM_LEDS];
        int unsigned        frame_pos;
        logic [RW_W-1:0]    reset_words;
        logic [CODE_W-1:0]  code_one;
        logic [CODE_W-1:0]  code_zero;
        t_slot_result       expected_slots[$];
        int unsigned        mismatches;

        function new();
            clear_colors();
            frame_pos   = 0;
            reset_words = RESET_WORDS_RST;
            code_one    = CODE_ONE_RST;
            code_zero   = CODE_ZERO_RST;
            mismatches  = 0;
        endfunction

        function void clear_colors();
            foreach (colors[k]) colors[k] = '0;
        endfunction

        function bit led_number_valid(logic [LED_NUM_W-1:0] n);
            return n >= 1 && n <= NUM_LEDS;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx,
                                     logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_RESET_WORDS: reset_words = data[RW_W-1:0];
                CFG_CODE_ONE:    code_one = data;
                CFG_CODE_ZERO:   code_zero = data;
                default: ;
            endcase
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [LED_NUM_W-1:0] first,
                                   logic [LED_NUM_W-1:0] last, logic [CHAN_W-1:0] red,
                                   logic [CHAN_W-1:0] green, logic [CHAN_W-1:0] blue);
            t_slot_result       res;
            logic [COLOR_W-1:0] color;
            int unsigned        total;
            int unsigned        slot;
            int unsigned        bit_sel;
            res = '0;
            color = {green, red, blue};
            case (cmd)
                CMD_SET_ALL: begin
                    foreach (colors[k]) colors[k] = color;
                    frame_pos = 0;
                end
                CMD_SET_INDEX: begin
                    clear_colors();
                    if (led_number_valid(first)) colors[first - 1] = color;
                    else res.status = 1'b1;
                    frame_pos = 0;
                end
                CMD_SET_RANGE: begin
                    clear_colors();
                    if (led_number_valid(first) && led_number_valid(last)) begin
                        for (int k = first; k <= last; k++) colors[k - 1] = color;
                    end else begin
                        res.status = 1'b1;
                    end
                    frame_pos = 0;
                end
                CMD_ALL_OFF: begin
                    clear_colors();
                    frame_pos = 0;
                end
                CMD_NEXT_CODE: begin
                    total = reset_words + FRAME_DATA_SLOTS;
                    // A frame shortened by a register write restarts from slot 0.
                    if (frame_pos >= total) frame_pos = 0;
                    if (frame_pos >= reset_words) begin
                        slot = frame_pos - reset_words;
                        bit_sel = TOP_BIT - (slot % SLOTS_PER_LED);
                        res.pulse_code = colors[slot / SLOTS_PER_LED][bit_sel] ?
                                         code_one : code_zero;
                    end
                    if (frame_pos + 1 == total) begin
                        res.frame_end = 1'b1;
                        frame_pos = 0;
                    end else begin
                        frame_pos++;
                    end
                end
                default: ;
            endcase
            expected_slots.push_back(res);
        endfunction

        function void check_result(logic status, logic [CODE_W-1:0] pulse_code,
                                   logic frame_end);
            t_slot_result want;
            if (expected_slots.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: status %0d code %0d frame_end %0d",
                             status, pulse_code, frame_end);
                return;
            end
            want = expected_slots.pop_front();
            if (status !== want.status || pulse_code !== want.pulse_code ||
                frame_end !== want.frame_end) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"mismatch: expected status %0d code %0d frame_end %0d, ",
                              "got status %0d code %0d frame_end %0d"},
                             want.status, want.pulse_code, want.frame_end,
                             status, pulse_code, frame_end);
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [CMD_W-1:0]      i_command = '0;
    logic [LED_NUM_W-1:0]  i_first_led = '0;
    logic [LED_NUM_W-1:0]  i_last_led = '0;
    logic [CHAN_W-1:0]     i_red = '0;
    logic [CHAN_W-1:0]     i_green = '0;
    logic [CHAN_W-1:0]     i_blue = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_status;
    logic [CODE_W-1:0]     o_pulse_code;
    logic                  o_frame_end;

    pulse_frame_board frame_board;
    int unsigned      stall_cycles = 0;
    bit               timed_out = 1'b0;
    int unsigned      burst_left = 0;
    int unsigned      max_gap = 0;
    t_ready_mode      ready_mode = READY_ALWAYS;
    int unsigned      ready_mode_left = 0;
    int unsigned      pattern_count = 0;

    led_strip_pulse_encoder_top #(
        .LED_COUNT(NUM_LEDS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .i_first_led (i_first_led),
        .i_last_led  (i_last_led),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_pulse_code(o_pulse_code),
        .o_frame_end (o_frame_end)
    );

    always #5 i_clk = ~i_clk;

    // Output checking, the stall counter and the receiver's ready pattern.
    // Values read here are the ones sampled at this edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                frame_board.check_result(o_status, o_pulse_code, o_frame_end);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
        if (ready_mode_left == 0) begin
            ready_mode = t_ready_mode'($urandom_range(0, 3));
            ready_mode_left = $urandom_range(16, 160);
        end
        ready_mode_left--;
        pattern_count++;
        case (ready_mode)
            READY_ALWAYS:  i_out_ready <= 1'b1;
            READY_COIN:    i_out_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE:  i_out_ready <= ($urandom_range(0, 3) == 0);
            default:       i_out_ready <= (pattern_count % 5) != 4;
        endcase
    end

    task automatic send_item(input logic [CMD_W-1:0] cmd,
                             input logic [LED_NUM_W-1:0] first,
                             input logic [LED_NUM_W-1:0] last, input logic [CHAN_W-1:0] red,
                             input logic [CHAN_W-1:0] green, input logic [CHAN_W-1:0] blue);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, max_gap);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_command   <= cmd;
        i_first_led <= first;
        i_last_led  <= last;
        i_red       <= red;
        i_green     <= green;
        i_blue      <= blue;
        do @(posedge i_clk); while (!o_in_ready);
        frame_board.note_command(cmd, first, last, red, green, blue);
    endtask

    task automatic send_next_codes(input int unsigned count);
        repeat (count)
            send_item(CMD_NEXT_CODE, LED_NUM_W'($urandom_range(0, 255)),
                      LED_NUM_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)),
                      CHAN_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)));
    endtask

    // Holds the input side off until every owed result has been seen.
    task automatic drain_results(input int unsigned settle);
        i_in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (frame_board.expected_slots.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        frame_board.write_register(idx, data);
    endtask

    task automatic send_random_edit();
        logic [LED_NUM_W-1:0] first;
        logic [LED_NUM_W-1:0] last;
        logic [CMD_W-1:0]     cmd;
        int unsigned          pick;
        pick = $urandom_range(0, 11);
        // Low LED numbers are favored so the short code runs that follow see lit slots.
        first = $urandom_range(0, 1) ? LED_NUM_W'($urandom_range(1, 3))
                                     : LED_NUM_W'($urandom_range(1, NUM_LEDS));
        last = LED_NUM_W'($urandom_range(first, NUM_LEDS));
        case (pick)
            0, 1:    cmd = CMD_SET_ALL;
            2, 3:    cmd = CMD_SET_INDEX;
            4, 5, 6: cmd = CMD_SET_RANGE;
            7: begin
                cmd = CMD_SET_RANGE;
                last = LED_NUM_W'($urandom_range(1, NUM_LEDS));
            end
            8:       cmd = CMD_ALL_OFF;
            9:       cmd = CMD_SPARE_FIRST +
                           CMD_W'($urandom_range(0, CMD_SPARE_LAST - CMD_SPARE_FIRST));
            default: begin
                cmd = $urandom_range(0, 1) ? CMD_SET_INDEX : CMD_SET_RANGE;
                first = LED_NUM_W'($urandom_range(0, 255));
                last = LED_NUM_W'($urandom_range(0, 255));
            end
        endcase
        send_item(cmd, first, last, CHAN_W'($urandom_range(0, 255)),
                  CHAN_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)));
    endtask

    task automatic randomize_registers();
        logic [RW_W-1:0]   rw;
        logic [CODE_W-1:0] one;
        logic [CODE_W-1:0] zero;
        case ($urandom_range(0, 5))
            0:       rw = '0;
            1:       rw = '1;
            2:       rw = RW_W'($urandom_range(0, 255));
            default: rw = RW_W'($urandom_range(0, 6));
        endcase
        case ($urandom_range(0, 3))
            0:       one = '0;
            1:       one = '1;
            default: one = CODE_W'($urandom_range(0, 65535));
        endcase
        case ($urandom_range(0, 3))
            0:       zero = '1;
            1:       zero = '0;
            default: zero = CODE_W'($urandom_range(0, 65535));
        endcase
        // Upper data bits are don't-care for reset_words but still toggled.
        write_register(CFG_RESET_WORDS, {8'($urandom_range(0, 255)), rw});
        write_register(CFG_CODE_ONE, one);
        write_register(CFG_CODE_ZERO, zero);
    endtask

    task automatic run_test();
        int unsigned items;
        int unsigned run_len;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: defaults first, then short latch gap and extreme codes.
        max_gap = 0;
        send_next_codes(2);
        drain_results(2);
        write_register(CFG_RESET_WORDS, {8'hA5, 8'd2});
        write_register(CFG_CODE_ONE, 16'hFFFF);
        write_register(CFG_CODE_ZERO, 16'h0000);
        send_item(CMD_SET_ALL, 8'd0, 8'd0, 8'hFF, 8'hFF, 8'hFF);
        send_next_codes(3);
        send_item(CMD_SET_INDEX, 8'd0, 8'd0, 8'h12, 8'h34, 8'h56);
        send_item(CMD_SET_INDEX, 8'd1, 8'd0, 8'h80, 8'h01, 8'h00);
        send_next_codes(3);
        send_item(CMD_SET_INDEX, 8'd64, 8'd0, 8'hAA, 8'h55, 8'hAA);
        send_item(CMD_SET_INDEX, 8'd65, 8'd0, 8'hAA, 8'h55, 8'hAA);
        send_item(CMD_SET_INDEX, 8'd255, 8'd255, 8'hFF, 8'hFF, 8'hFF);
        send_item(CMD_SET_RANGE, 8'd1, 8'd64, 8'h00, 8'h80, 8'h00);
        send_next_codes(3);
        send_item(CMD_SET_RANGE, 8'd0, 8'd5, 8'h11, 8'h22, 8'h33);
        send_item(CMD_SET_RANGE, 8'd5, 8'd0, 8'h11, 8'h22, 8'h33);
        send_item(CMD_SET_RANGE, 8'd10, 8'd3, 8'h11, 8'h22, 8'h33);
        send_item(CMD_SET_RANGE, 8'd64, 8'd64, 8'h44, 8'h55, 8'h66);
        send_item(CMD_SET_RANGE, 8'd3, 8'd65, 8'h44, 8'h55, 8'h66);
        send_item(CMD_ALL_OFF, 8'd255, 8'd255, 8'hFF, 8'hFF, 8'hFF);
        send_item(CMD_SPARE_FIRST, 8'd1, 8'd1, 8'h01, 8'h01, 8'h01);
        send_item(CMD_SPARE_FIRST + 3'd1, 8'd2, 8'd2, 8'h02, 8'h02, 8'h02);
        send_item(CMD_SPARE_LAST, 8'd3, 8'd3, 8'h03, 8'h03, 8'h03);
        send_next_codes(2);

        // Long latch gap, walk deep into the data, then shrink the frame under
        // the current position and walk one whole frame through its wrap.
        drain_results(2);
        write_register(CFG_RESET_WORDS, 16'h00FF);
        write_register(CFG_CODE_ONE, CFG_DATA_W'($urandom_range(0, 65535)));
        write_register(CFG_CODE_ZERO, CFG_DATA_W'($urandom_range(0, 65535)));
        write_register(CFG_SPARE, CFG_DATA_W'($urandom_range(0, 65535)));
        max_gap = 2;
        send_item(CMD_SET_RANGE, LED_NUM_W'($urandom_range(1, 20)),
                  LED_NUM_W'($urandom_range(40, NUM_LEDS)), CHAN_W'($urandom_range(0, 255)),
                  CHAN_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)));
        send_next_codes(FRAME_DATA_SLOTS + 4);
        drain_results(2);
        write_register(CFG_RESET_WORDS, {8'($urandom_range(0, 255)), 8'd3});
        send_next_codes(FRAME_DATA_SLOTS + 5);

        // Random: an edit followed by a run of code requests, with register
        // changes and full pauses between some of the runs.
        items = 0;
        while (items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 7))
                0, 1: begin
                    drain_results(2);
                    randomize_registers();
                end
                2:       drain_results(0);
                default: ;
            endcase
            case ($urandom_range(0, 2))
                0:       max_gap = 0;
                1:       max_gap = 2;
                default: max_gap = 8;
            endcase
            send_random_edit();
            run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 40);
            send_next_codes(run_len);
            items += run_len + 1;
        end
        drain_results(DRAIN_CYCLES);
    endtask

    initial begin
        frame_board = new();
        fork
            run_test();
            begin
                wait (stall_cycles >= STALL_LIMIT);
                timed_out = 1'b1;
            end
        join_any
        if (!timed_out && frame_board.mismatches == 0 &&
            frame_board.expected_slots.size() == 0) begin
            $display("[led_strip_pulse_encoder_top] OK");
        end else begin
            $display("[led_strip_pulse_encoder_top] ERROR");
        end
        $finish;
    end

endmodule

// ===== led_strip_pulse_encoder_top.f =====
+incdir+rtl
rtl/lspe_pkg.sv
rtl/lspe_ctrl.sv
rtl/lspe_datapath.sv
rtl/led_strip_pulse_encoder_top.sv
verif/tb_led_strip_pulse_encoder_top.sv
